### sv/fan_curve_and_tacho_controller_defines.svh
// assertion macros shared by the fan controller rtl
`ifndef FAN_CURVE_AND_TACHO_CONTROLLER_DEFINES_SVH
`define FAN_CURVE_AND_TACHO_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_PROP(lbl, !(cond), msg)
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### sv/fctc_pkg.sv
// types, constants and the temperature curve of the fan controller
package fctc_pkg;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [2:0] ACT_EDGE = 3'd0;
    localparam logic [2:0] ACT_MEAS = 3'd1;
    localparam logic [2:0] ACT_REQ  = 3'd2;
    localparam logic [2:0] ACT_TEMP = 3'd3;
    localparam logic [2:0] ACT_ADJ  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_PER_EDGE = 2'd2;

    localparam logic [15:0] RST_PWM_TOP      = 16'd4999;
    localparam logic [6:0]  RST_MIN_DUTY     = 7'd20;
    localparam logic [7:0]  RST_RPM_PER_EDGE = 8'd6;
    localparam logic [15:0] RST_SPEED        = 16'hBEEF;
    localparam logic [15:0] RST_TEMP         = 16'h0BAD;
    localparam logic [6:0]  RST_DUTY         = 7'd20;

    localparam logic [6:0]  DUTY_MAX    = 7'd100;
    localparam logic [23:0] LEVEL_RECIP = 24'd10737419;
    localparam int          LEVEL_SHIFT = 30;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    localparam int CURVE_ROWS = 9;
    localparam int CURVE_LO   [CURVE_ROWS] = '{0, 2400, 2600, 2800, 3000, 3100, 3200, 3300, 3400};
    localparam int CURVE_HI   [CURVE_ROWS] = '{2400, 2600, 2800, 3000, 3100, 3200, 3300, 3400,
                                               10000};
    localparam int CURVE_DUTY [CURVE_ROWS] = '{20, 30, 40, 50, 60, 70, 80, 90, 100};

    typedef enum logic [2:0] {
        K_EDGE,
        K_MEAS,
        K_REQ,
        K_TEMP,
        K_ADJ
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [2:0]         fan;
        logic [7:0]         req;
        logic signed [15:0] temp;
    } t_cmd;

    typedef struct packed {
        logic [15:0] pwm_top;
        logic [6:0]  min_duty;
        logic [7:0]  rpm_per_edge;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // returns {hit, duty}
    function automatic logic [7:0] curve_lookup(input logic signed [15:0] t);
        logic       hit;
        logic [6:0] duty;
        hit  = 1'b0;
        duty = 7'd0;
        for (int r = 0; r < CURVE_ROWS; r++) begin
            if (CURVE_LO[r] < int'(t) && int'(t) <= CURVE_HI[r]) begin
                hit  = 1'b1;
                duty = 7'(CURVE_DUTY[r]);
            end
        end
        return {hit, duty};
    endfunction

endpackage

### sv/fctc_front.sv
// input side: takes words, sorts them into commands, drops the ones with no effect
module fctc_front #(
    parameter int NUM_FANS = 7
) (
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [fctc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic [fctc_pkg::IN_USER_W-1:0]    s_axis_tuser,
    input  fctc_pkg::t_q_status               i_q,
    output logic                              o_push,
    output fctc_pkg::t_cmd                    o_cmd
);
    import fctc_pkg::*;

    logic       fan_ok;
    logic       keep;
    logic [2:0] fan;

    assign fan           = s_axis_tdata[2:0];
    assign fan_ok        = {1'b0, fan} < 4'(NUM_FANS);
    assign s_axis_tready = !i_q.full;
    assign o_push        = s_axis_tvalid && s_axis_tready && keep;

    always_comb begin
        o_cmd.fan  = fan;
        o_cmd.req  = s_axis_tdata[10:3];
        o_cmd.temp = s_axis_tdata[26:11];
        o_cmd.kind = K_EDGE;
        keep       = 1'b0;
        unique case (s_axis_tuser)
            ACT_EDGE: begin
                o_cmd.kind = K_EDGE;
                keep       = fan_ok;
            end
            ACT_MEAS: begin
                o_cmd.kind = K_MEAS;
                keep       = 1'b1;
            end
            ACT_REQ: begin
                o_cmd.kind = K_REQ;
                keep       = fan_ok;
            end
            ACT_TEMP: begin
                o_cmd.kind = K_TEMP;
                keep       = fan_ok;
            end
            ACT_ADJ: begin
                o_cmd.kind = K_ADJ;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

### sv/fctc_queue.sv
// short command queue between the input side and the executor
`include "fan_curve_and_tacho_controller_defines.svh"

module fctc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fctc_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output fctc_pkg::t_cmd      o_cmd,
    output fctc_pkg::t_q_status o_status
);
    import fctc_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_CW-1:0] r_count;

    assign o_cmd          = r_mem[r_rd];
    assign o_status.full  = r_count == QUEUE_CW'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_push && o_status.full, "push into full queue")
    `ASSERT_NEVER(a_no_underflow, i_pop && o_status.empty, "pop from empty queue")
    `ASSERT_PROP(a_push_fills, (i_push && !i_pop) |=> !o_status.empty, "pushed word lost")

endmodule

### sv/fctc_back.sv
// executor: per-fan state, tick sweeps, level arithmetic and the result register
`include "fan_curve_and_tacho_controller_defines.svh"

module fctc_back #(
    parameter int NUM_FANS = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fctc_pkg::t_cfg                  i_cfg,
    input  fctc_pkg::t_q_status             i_q,
    input  fctc_pkg::t_cmd                  i_cmd,
    output logic                            o_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fctc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import fctc_pkg::*;

    localparam int          FW       = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;
    localparam logic [FW-1:0] LAST_IDX = FW'(NUM_FANS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_MUL1,
        S_MUL2,
        S_OUT
    } t_state;

    t_state      r_state;
    t_kind       r_kind;
    logic [FW-1:0] r_idx;

    logic [15:0] r_count [NUM_FANS];
    logic [15:0] r_speed [NUM_FANS];
    logic [15:0] r_temp  [NUM_FANS];
    logic        r_auto  [NUM_FANS];
    logic [6:0]  r_duty  [NUM_FANS];

    logic [23:0] r_prod;
    logic [47:0] r_quot;

    logic        r_valid;
    logic        r_last;
    logic [2:0]  r_out_fan;
    logic [6:0]  r_out_duty;
    logic [16:0] r_out_level;
    logic [15:0] r_out_speed;
    logic        r_out_auto;

    logic [FW-1:0] rd_idx;
    logic [15:0]   cur_count;
    logic [6:0]    cur_duty;
    logic [6:0]    floor_duty;
    logic [23:0]   meas_prod;
    logic [15:0]   meas_sat;
    logic [16:0]   top1;
    logic [7:0]    curve;
    logic          out_load;
    logic          out_fire;

    assign rd_idx     = (r_state == S_IDLE) ? i_cmd.fan[FW-1:0] : r_idx;
    assign cur_count  = r_count[rd_idx];
    assign cur_duty   = r_duty[rd_idx];
    assign floor_duty = (i_cfg.min_duty > DUTY_MAX) ? DUTY_MAX : i_cfg.min_duty;
    assign meas_prod  = 24'(cur_count) * 24'(i_cfg.rpm_per_edge);
    assign meas_sat   = (meas_prod[23:16] != 8'd0) ? 16'hFFFF : meas_prod[15:0];
    assign top1       = 17'(i_cfg.pwm_top) + 17'd1;
    assign curve      = curve_lookup(r_temp[rd_idx]);
    assign out_load   = !r_valid || m_axis_tready;
    assign out_fire   = (r_state == S_OUT) && out_load;
    assign o_pop      = (r_state == S_IDLE) && !i_q.empty;

    assign m_axis_tvalid = r_valid;
    assign m_axis_tlast  = r_last;
    // out_fan, duty_percent, duty_level, speed_rpm, auto_flag
    assign m_axis_tdata  = {4'd0, r_out_auto, r_out_speed, r_out_level, r_out_duty, r_out_fan};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_EDGE;
            r_idx   <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            for (int i = 0; i < NUM_FANS; i++) begin
                r_count[i] <= 16'd0;
                r_speed[i] <= RST_SPEED;
                r_temp[i]  <= RST_TEMP;
                r_auto[i]  <= 1'b1;
                r_duty[i]  <= RST_DUTY;
            end
        end else begin
            if (out_fire) begin
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (i_cmd.kind)
                            K_EDGE: begin
                                if (cur_count != 16'hFFFF) begin
                                    r_count[rd_idx] <= cur_count + 16'd1;
                                end
                            end
                            K_REQ: begin
                                if (i_cmd.req > {1'b0, DUTY_MAX}) begin
                                    r_auto[rd_idx] <= 1'b1;
                                end else begin
                                    r_auto[rd_idx] <= 1'b0;
                                    r_duty[rd_idx] <= (i_cmd.req < {1'b0, floor_duty}) ?
                                                      floor_duty : i_cmd.req[6:0];
                                end
                            end
                            K_TEMP: begin
                                r_temp[rd_idx] <= i_cmd.temp;
                            end
                            K_MEAS, K_ADJ: begin
                                r_kind  <= i_cmd.kind;
                                r_idx   <= '0;
                                r_state <= S_UPD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_UPD: begin
                    if (r_kind == K_MEAS) begin
                        r_speed[rd_idx] <= meas_sat;
                        r_count[rd_idx] <= 16'd0;
                    end else if (r_auto[rd_idx]) begin
                        if (curve[7]) begin
                            r_duty[rd_idx] <= curve[6:0];
                        end
                    end else if (cur_duty < floor_duty) begin
                        r_duty[rd_idx] <= floor_duty;
                    end
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_prod  <= 24'(cur_duty) * 24'(top1);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_quot  <= 48'(r_prod) * 48'(LEVEL_RECIP);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_last      <= r_idx == LAST_IDX;
                        r_out_fan   <= 3'(r_idx);
                        r_out_duty  <= cur_duty;
                        r_out_level <= r_quot[LEVEL_SHIFT+16:LEVEL_SHIFT];
                        r_out_speed <= r_speed[rd_idx];
                        r_out_auto  <= r_auto[rd_idx];
                        if (r_idx == LAST_IDX) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_UPD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_PROP(a_last_on_final, out_fire |=> (r_last == (r_out_fan == 3'(LAST_IDX))), "bad tlast")
    `ASSERT_PROP(a_duty_range, r_valid |-> (r_out_duty <= DUTY_MAX), "duty above full scale")
    `ASSERT_PROP(a_level_range, r_valid |-> (r_out_level <= 17'h10000), "level above full scale")

endmodule

### sv/fan_curve_and_tacho_controller.sv
// top level of the multi-fan curve and tacho controller
//
//  channel   | direction | handshake                      | content
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | event word, action in tuser
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | per-fan status, tlast on last fan
//  cfg       | in        | i_cfg_valid / o_cfg_ready      | register index and value
//
// edge, request and sample words are applied by the executor as it pops them from the queue
// measure and adjust ticks sweep every fan through update, two multiply stages and
// result load; the result load waits while m_axis stalls
// the four-word queue keeps s_axis open while the executor sweeps, until the queue is full
// synchronous reset sets all per-fan state at once, no clearing pass
`include "fan_curve_and_tacho_controller_defines.svh"

module fan_curve_and_tacho_controller #(
    parameter int NUM_FANS = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // fan_index, duty_request, temperature
    input  logic [fctc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [fctc_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_fan, duty_percent, duty_level, speed_rpm, auto_flag
    output logic [fctc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fctc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fctc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fctc_pkg::*;

    t_cfg      r_cfg;
    t_q_status q_status;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    logic      push;
    logic      pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pwm_top      <= RST_PWM_TOP;
            r_cfg.min_duty     <= RST_MIN_DUTY;
            r_cfg.rpm_per_edge <= RST_RPM_PER_EDGE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PWM_TOP:      r_cfg.pwm_top      <= i_cfg_data;
                CFG_MIN_DUTY:     r_cfg.min_duty     <= i_cfg_data[6:0];
                CFG_RPM_PER_EDGE: r_cfg.rpm_per_edge <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    fctc_front #(
        .NUM_FANS (NUM_FANS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q           (q_status),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    fctc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    fctc_back #(
        .NUM_FANS (NUM_FANS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q           (q_status),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    `ASSERT_PROP(a_min_duty_range, m_axis_tvalid |-> (m_axis_tdata[9:3] <= DUTY_MAX), "duty range")
    `ASSERT_PROP(a_ready_when_room, !q_status.full |-> s_axis_tready, "input stalled with room")
    `ASSERT_PROP(a_pad_zero, m_axis_tvalid |-> (m_axis_tdata[47:44] == 4'd0), "padding bits set")

endmodule

### tb/fan_curve_and_tacho_controller_test.sv
// self-checking testbench for the fan curve and tacho controller with a built-in fan predictor
module fan_curve_and_tacho_controller_test;
    import fctc_pkg::*;

    localparam int FANS = 7;
    localparam logic [2:0] ACT_UNUSED = 3'd5;
    localparam logic [2:0] ACT_TOP    = 3'd7;
    localparam int BANDS = 9;
    localparam int BAND_LO   [BANDS] = '{0, 2400, 2600, 2800, 3000, 3100, 3200, 3300, 3400};
    localparam int BAND_HI   [BANDS] = '{2400, 2600, 2800, 3000, 3100, 3200, 3300, 3400, 10000};
    localparam int BAND_DUTY [BANDS] = '{20, 30, 40, 50, 60, 70, 80, 90, 100};
    localparam int DIR_ROWS = 23;

    typedef struct packed {
        logic [2:0]  act;
        logic [2:0]  fan;
        logic [7:0]  req;
        logic [15:0] temp;
        logic        typed;
        logic [6:0]  e_duty;
        logic [16:0] e_level;
        logic [15:0] e_rpm;
        logic        e_auto;
    } event_t;

    typedef struct packed {
        logic [2:0]  fan;
        logic [6:0]  duty;
        logic [16:0] level;
        logic [15:0] rpm;
        logic        auto_on;
        logic        is_last;
    } fan_status_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [15:0] fan_edges [FANS];
    logic [15:0] fan_rpm   [FANS];
    logic [15:0] fan_temp  [FANS];
    logic        fan_auto  [FANS];
    logic [6:0]  fan_duty  [FANS];
    logic [15:0] top_val;
    logic [6:0]  min_duty_val;
    logic [7:0]  rpm_step_val;

    fan_status_t pending_status [$];
    int  errors = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;

    event_t script [DIR_ROWS] = '{
        '{ACT_ADJ,  3'd0, 8'd0,   16'd0,     1'b1, 7'd50, 17'd2500, 16'hBEEF, 1'b1},
        '{ACT_MEAS, 3'd0, 8'd0,   16'd0,     1'b1, 7'd50, 17'd2500, 16'd0,    1'b1},
        '{ACT_TEMP, 3'd0, 8'd0,   16'h8000,  1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_TEMP, 3'd1, 8'd0,   16'h7FFF,  1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_TEMP, 3'd2, 8'd0,   16'd0,     1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_TEMP, 3'd3, 8'd0,   16'd2400,  1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_TEMP, 3'd4, 8'd0,   16'd2401,  1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_TEMP, 3'd5, 8'd0,   16'd10000, 1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_TEMP, 3'd6, 8'd0,   16'd10001, 1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_TEMP, 3'd7, 8'd0,   16'd3000,  1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_REQ,  3'd0, 8'd0,   16'd0,     1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_REQ,  3'd1, 8'd100, 16'd0,     1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_REQ,  3'd2, 8'd255, 16'd0,     1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_REQ,  3'd7, 8'd50,  16'd0,     1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_REQ,  3'd3, 8'd101, 16'd0,     1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_EDGE, 3'd0, 8'd0,   16'd0,     1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_EDGE, 3'd0, 8'd0,   16'd0,     1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_EDGE, 3'd6, 8'd0,   16'd0,     1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_EDGE, 3'd7, 8'd0,   16'd0,     1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_UNUSED, 3'd0, 8'd9, 16'd4000,  1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_TOP,  3'd6, 8'd1,   16'd2500,  1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_ADJ,  3'd0, 8'd0,   16'd0,     1'b0, 7'd0,  17'd0,    16'd0,    1'b0},
        '{ACT_MEAS, 3'd0, 8'd0,   16'd0,     1'b0, 7'd0,  17'd0,    16'd0,    1'b0}
    };

    fan_curve_and_tacho_controller #(
        .NUM_FANS(FANS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (errors < 100) begin
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        end
        errors++;
    endtask

    function automatic void reset_fans();
        for (int i = 0; i < FANS; i++) begin
            fan_edges[i] = '0;
            fan_rpm[i]   = RST_SPEED;
            fan_temp[i]  = RST_TEMP;
            fan_auto[i]  = 1'b1;
            fan_duty[i]  = RST_DUTY;
        end
        top_val      = RST_PWM_TOP;
        min_duty_val = RST_MIN_DUTY;
        rpm_step_val = RST_RPM_PER_EDGE;
    endfunction

    function automatic void queue_fan_status(input int f, input event_t w);
        fan_status_t s;
        int unsigned lv;
        lv = 32'(fan_duty[f]) * (32'(top_val) + 32'd1) / 32'd100;
        s.fan     = f[2:0];
        s.duty    = fan_duty[f];
        s.level   = lv[16:0];
        s.rpm     = fan_rpm[f];
        s.auto_on = fan_auto[f];
        s.is_last = (f == FANS - 1);
        if (w.typed) begin
            s.duty    = w.e_duty;
            s.level   = w.e_level;
            s.rpm     = w.e_rpm;
            s.auto_on = w.e_auto;
        end
        pending_status.push_back(s);
    endfunction

    function automatic void advance_fans(input event_t w);
        logic [6:0]  lim;
        int unsigned prod;
        int          t;
        bit          ok;
        lim = (min_duty_val > DUTY_MAX) ? DUTY_MAX : min_duty_val;
        ok  = (int'(w.fan) < FANS);
        case (w.act)
            ACT_EDGE: begin
                if (ok && fan_edges[w.fan] != 16'hFFFF) fan_edges[w.fan]++;
            end
            ACT_MEAS: begin
                for (int i = 0; i < FANS; i++) begin
                    prod = 32'(fan_edges[i]) * 32'(rpm_step_val);
                    fan_rpm[i]   = (prod > 32'hFFFF) ? 16'hFFFF : prod[15:0];
                    fan_edges[i] = '0;
                    queue_fan_status(i, w);
                end
            end
            ACT_REQ: begin
                if (ok) begin
                    if (w.req > 8'(DUTY_MAX)) begin
                        fan_auto[w.fan] = 1'b1;
                    end else begin
                        fan_auto[w.fan] = 1'b0;
                        fan_duty[w.fan] = (w.req < 8'(lim)) ? lim : w.req[6:0];
                    end
                end
            end
            ACT_TEMP: begin
                if (ok) fan_temp[w.fan] = w.temp;
            end
            ACT_ADJ: begin
                for (int i = 0; i < FANS; i++) begin
                    if (fan_auto[i]) begin
                        t = int'($signed(fan_temp[i]));
                        for (int r = 0; r < BANDS; r++) begin
                            if (BAND_LO[r] < t && t <= BAND_HI[r]) fan_duty[i] = 7'(BAND_DUTY[r]);
                        end
                    end else if (fan_duty[i] < lim) begin
                        fan_duty[i] = lim;
                    end
                    queue_fan_status(i, w);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic drive_word(input event_t w);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(5, 0) == 0) gap = $urandom_range(18, 1);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, w.temp, w.req, w.fan};
        s_axis_tuser  <= w.act;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_fans(w);
    endtask

    task automatic send_event(input logic [2:0] act, input logic [2:0] fan, input logic [7:0] req,
                              input logic [15:0] temp);
        event_t w;
        w = '0;
        w.act  = act;
        w.fan  = fan;
        w.req  = req;
        w.temp = temp;
        drive_word(w);
    endtask

    task automatic send_random(input int count);
        event_t w;
        int     r;
        repeat (count) begin
            w      = '0;
            w.fan  = 3'($urandom_range(7, 0));
            w.req  = 8'($urandom_range(255, 0));
            w.temp = 16'($urandom_range(65535, 0));
            r = $urandom_range(99, 0);
            if (r < 38) begin
                w.act = ACT_EDGE;
            end else if (r < 52) begin
                w.act = ACT_REQ;
                if ($urandom_range(3, 0) != 0) w.req = 8'($urandom_range(100, 0));
            end else if (r < 70) begin
                w.act = ACT_TEMP;
                case ($urandom_range(3, 0))
                    0: ;
                    1: w.temp = 16'($urandom_range(10400, 0));
                    default: w.temp = 16'($urandom_range(3500, 2300));
                endcase
            end else if (r < 82) begin
                w.act = ACT_MEAS;
            end else if (r < 96) begin
                w.act = ACT_ADJ;
            end else begin
                w.act = 3'($urandom_range(ACT_TOP, ACT_UNUSED));
            end
            drive_word(w);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PWM_TOP:      top_val      = val;
            CFG_MIN_DUTY:     min_duty_val = val[6:0];
            CFG_RPM_PER_EDGE: rpm_step_val = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (4 * FANS + 8) @(posedge i_clk);
    endtask

    // result side: random back-pressure plus one long hold on request
    initial begin : result_sink
        int burst;
        int hold_left;
        burst = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = 400;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(7, 0) == 0) begin
                burst = $urandom_range(18, 1) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : status_check
        fan_status_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_status.size() == 0) begin
                report("unexpected word, fan", 32'(m_axis_tdata[2:0]), 32'd0);
            end else begin
                want = pending_status.pop_front();
                if (m_axis_tdata[2:0] !== want.fan)
                    report("out_fan", 32'(m_axis_tdata[2:0]), 32'(want.fan));
                if (m_axis_tdata[9:3] !== want.duty)
                    report("duty_percent", 32'(m_axis_tdata[9:3]), 32'(want.duty));
                if (m_axis_tdata[26:10] !== want.level)
                    report("duty_level", 32'(m_axis_tdata[26:10]), 32'(want.level));
                if (m_axis_tdata[42:27] !== want.rpm)
                    report("speed_rpm", 32'(m_axis_tdata[42:27]), 32'(want.rpm));
                if (m_axis_tdata[43] !== want.auto_on)
                    report("auto_flag", 32'(m_axis_tdata[43]), 32'(want.auto_on));
                if (m_axis_tlast !== want.is_last)
                    report("tlast", 32'(m_axis_tlast), 32'(want.is_last));
            end
        end
    end

    initial begin
        reset_fans();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) drive_word(script[i]);
        settle();

        // widest level scale, highest floor, fastest rpm step
        write_reg(CFG_PWM_TOP, 16'hFFFF);
        write_reg(CFG_MIN_DUTY, 16'd100);
        write_reg(CFG_RPM_PER_EDGE, 16'd255);
        repeat (40) send_event(ACT_EDGE, 3'd1, 8'd0, 16'd0);
        send_event(ACT_MEAS, 3'd0, 8'd0, 16'd0);
        hold_req = 1'b1;
        repeat (12) send_event(ACT_ADJ, 3'd0, 8'd0, 16'd0);
        send_random(30);
        settle();

        // narrow scale, no floor, short back to back edge run
        write_reg(CFG_PWM_TOP, 16'd1);
        write_reg(CFG_MIN_DUTY, 16'd0);
        write_reg(CFG_RPM_PER_EDGE, 16'd1);
        send_event(ACT_REQ, 3'd5, 8'd3, 16'd0);
        calm = 1'b1;
        repeat (4) send_event(ACT_EDGE, 3'd3, 8'd0, 16'd0);
        send_event(ACT_MEAS, 3'd0, 8'd0, 16'd0);
        calm = 1'b0;
        send_random(30);
        settle();

        // floor above the full duty
        write_reg(CFG_MIN_DUTY, 16'd127);
        write_reg(CFG_PWM_TOP, 16'($urandom_range(65535, 1)));
        write_reg(CFG_RPM_PER_EDGE, 16'($urandom_range(255, 1)));
        send_event(ACT_ADJ, 3'd0, 8'd0, 16'd0);
        send_random(30);
        settle();

        write_reg(CFG_PWM_TOP, 16'($urandom_range(65535, 1)));
        write_reg(CFG_MIN_DUTY, 16'($urandom_range(100, 0)));
        write_reg(CFG_RPM_PER_EDGE, 16'($urandom_range(255, 1)));
        calm = 1'b1;
        send_random(36);
        settle();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
